// ===== hw/rtl/descending_integer_sorter_core_macros.svh =====
// Assertion helpers for the asserting file of the sorter.
`ifndef DESCENDING_INTEGER_SORTER_CORE_MACROS_SVH
`define DESCENDING_INTEGER_SORTER_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DIS_ASSERT_IMP(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define DIS_ASSERT_NXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/dis_pkg.sv =====
`default_nettype none
package dis_pkg;

  localparam int DIS_VALUE_W   = 32;
  localparam int DIS_MAX_ITEMS = 64;

  typedef struct packed {
    logic                          valid;
    logic signed [DIS_VALUE_W-1:0] value;
  } dis_elem_t;

  typedef enum logic [2:0] {
    ST_LOAD   = 3'b001,
    ST_SETTLE = 3'b010,
    ST_DRAIN  = 3'b100
  } dis_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/dis_stream_if.sv =====
`default_nettype none
interface dis_in_if import dis_pkg::*;;
  logic                          valid;
  logic                          ready;
  logic signed [DIS_VALUE_W-1:0] value;
  logic                          last;

  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

interface dis_out_if import dis_pkg::*;;
  logic                          valid;
  logic                          ready;
  logic signed [DIS_VALUE_W-1:0] sorted_value;
  logic                          last_out;
  logic                          overflow;

  modport source (output valid, output sorted_value, output last_out, output overflow,
                  input ready);
  modport sink (input valid, input sorted_value, input last_out, input overflow,
                output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/dis_cell.sv =====
`default_nettype none
module dis_cell import dis_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      shift,
  input  wire dis_elem_t carry_in,
  input  wire dis_elem_t neighbor,
  output dis_elem_t      held,
  output dis_elem_t      carry_out
);

  // The cell keeps the larger of its word and the arriving word and passes
  // the smaller one down the chain on the next cycle; on shift it takes its neighbor's word.
  always_ff @(posedge clk) begin
    if (rst) begin
      held.valid      <= 1'b0;
      carry_out.valid <= 1'b0;
    end else if (shift) begin
      held            <= neighbor;
      carry_out.valid <= 1'b0;
    end else if (carry_in.valid) begin
      if (!held.valid) begin
        held            <= carry_in;
        carry_out.valid <= 1'b0;
      end else if (carry_in.value > held.value) begin
        held.value      <= carry_in.value;
        carry_out       <= held;
      end else begin
        carry_out       <= carry_in;
      end
    end else begin
      carry_out.valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/dis_cell_chain.sv =====
`default_nettype none
module dis_cell_chain import dis_pkg::*; #(
  parameter int MAX_ITEMS = DIS_MAX_ITEMS
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire dis_elem_t load,
  input  wire logic      shift,
  output dis_elem_t      head,
  output logic           busy
);

  dis_elem_t entry;
  dis_elem_t held  [MAX_ITEMS];
  dis_elem_t carry [MAX_ITEMS];

  // Entry register feeds the first cell, so the first compare starts from a flop.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      entry <= load;
    end
  end

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    dis_elem_t c_in;
    dis_elem_t nb;

    if (i == 0) begin : g_first
      assign c_in = entry;
    end else begin : g_mid
      assign c_in = carry[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_end
      assign nb = '{valid: 1'b0, value: '0};
    end else begin : g_inner
      assign nb = held[i+1];
    end

    dis_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift     (shift),
      .carry_in  (c_in),
      .neighbor  (nb),
      .held      (held[i]),
      .carry_out (carry[i])
    );
  end

  always_comb begin
    busy = entry.valid;
    for (int i = 0; i < MAX_ITEMS; i++) begin
      busy = busy | carry[i].valid;
    end
  end

  assign head = held[0];

endmodule
`default_nettype wire

// ===== hw/rtl/descending_integer_sorter_core.sv =====
// Descending integer sorter.
// Words arrive on din, one signed 32-bit value each; din.last marks the
// final word of a list. Each accepted word enters a row of compare cells
// that keep the larger value and pass the smaller one to the next cell, so
// loading takes a new word while earlier ones still move down the row. Up
// to MAX_ITEMS words are kept; further words of the same list are dropped
// and overflow is raised on every result. After the word with last, the
// block stops taking input until the last insertion wave has run down the
// row. The list then leaves on dout in descending order, one word per
// cycle, the head cell shifting the row up by one on each accepted word;
// last_out marks the final result. If the receiver stalls, the head word
// and its flags hold until taken. Reset empties all cells and clears the
// count and the overflow flag; the block is ready for input in the cycle
// after reset is released.
`default_nettype none
`include "descending_integer_sorter_core_macros.svh"
module descending_integer_sorter_core import dis_pkg::*; #(
  parameter int MAX_ITEMS = DIS_MAX_ITEMS
) (
  input  wire logic clk,
  input  wire logic rst,
  dis_in_if.sink    din,
  dis_out_if.source dout
);

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITEMS);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  dis_state_t       state;
  logic [CNT_W-1:0] count;      // words stored in the current list
  logic [CNT_W-1:0] remaining;  // words still to be sent while draining
  logic             ovf;        // a word of this list was dropped

  dis_elem_t        load;
  dis_elem_t        head;
  logic             busy;
  logic             shift;
  logic             in_acc;
  logic             out_acc;
  logic             room;
  logic [CNT_W-1:0] count_next;

  assign din.ready = (state == ST_LOAD);
  assign in_acc    = din.valid && din.ready;
  assign room      = (count < CNT_MAX);
  assign count_next = room ? count + CNT_ONE : count;

  assign load.valid = in_acc && room;
  assign load.value = din.value;

  // Results come straight from the head cell of the chain.
  assign dout.valid        = (state == ST_DRAIN);
  assign dout.sorted_value = head.value;
  assign dout.last_out     = (remaining == CNT_ONE);
  assign dout.overflow     = ovf;
  assign out_acc           = dout.valid && dout.ready;
  assign shift             = out_acc;

  dis_cell_chain #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_chain (
    .clk   (clk),
    .rst   (rst),
    .load  (load),
    .shift (shift),
    .head  (head),
    .busy  (busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      remaining <= '0;
      ovf       <= 1'b0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (in_acc) begin
            count <= count_next;
            if (!room) begin
              ovf <= 1'b1;
            end
            if (din.last) begin
              remaining <= count_next;
              state     <= ST_SETTLE;
            end
          end
        end
        ST_SETTLE: begin
          // Wait until no compare wave is still moving down the row.
          if (!busy) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (out_acc) begin
            remaining <= remaining - CNT_ONE;
            if (remaining == CNT_ONE) begin
              count <= '0;
              ovf   <= 1'b0;
              state <= ST_LOAD;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // A word on dout must come from a filled head cell.
  `DIS_ASSERT_IMP(a_head_filled, dout.valid, head.valid, "result shown from an empty head cell")
  // Draining never runs with nothing left to send.
  `DIS_ASSERT_IMP(a_remaining_nonzero, dout.valid, remaining != '0, "drain with zero count")
  // The final result returns the block to loading with the row empty.
  `DIS_ASSERT_NXT(a_back_to_load, out_acc && dout.last_out, state == ST_LOAD && !head.valid,
                  "block not empty after final result")
  // The stored count never passes capacity.
  `DIS_ASSERT_IMP(a_count_bound, state == ST_LOAD, count <= CNT_MAX, "count beyond capacity")

endmodule
`default_nettype wire

// ===== bench/tb_descending_integer_sorter_core.sv =====
`default_nettype none
module tb_descending_integer_sorter_core import dis_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // Hard stop for the whole run. The slowest legal run is far below this
  // figure, even with long gaps on both sides.
  localparam int CYCLE_LIMIT = 300000;
  // Quiet cycles after the final result. This is well above the settle time
  // of a full row of cells, so a stray extra word would still be seen.
  localparam int DRAIN_CYCLES = 200;
  // Minimum number of input words in the whole run, counted over whole lists.
  localparam int RANDOM_WORDS = 320;

  localparam logic signed [DIS_VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;
  localparam logic signed [DIS_VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;

  // One input word waiting for the driver. The gap is the number of idle
  // cycles that the driver inserts after the word has been taken.
  typedef struct {
    logic signed [DIS_VALUE_W-1:0] value;
    logic                          last;
    int                            gap;
  } input_word_t;

  // One predicted output word.
  typedef struct {
    logic signed [DIS_VALUE_W-1:0] sorted_value;
    logic                          last_out;
    logic                          overflow;
  } sorted_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Driver-side copies of the channel inputs. Their initializers keep the
  // block's inputs at known values from time zero.
  logic                          in_valid = 1'b0;
  logic signed [DIS_VALUE_W-1:0] in_value = '0;
  logic                          in_last  = 1'b0;
  logic                          out_ready = 1'b0;

  int unsigned cycle_count = 0;
  int          error_count = 0;
  int          idle_left = 0;
  int          stall_left = 0;

  input_word_t  pending_words[$];
  sorted_word_t sorted_expect[$];

  // Predictor state: the words of the list being collected, and whether a
  // word of that list found the store full.
  logic signed [DIS_VALUE_W-1:0] held_values[$];
  logic                          held_overflow = 1'b0;

  dis_in_if  din_bus();
  dis_out_if dout_bus();

  assign din_bus.valid = in_valid;
  assign din_bus.value = in_value;
  assign din_bus.last  = in_last;
  assign dout_bus.ready = out_ready;

  descending_integer_sorter_core #(
    .MAX_ITEMS(DIS_MAX_ITEMS)
  ) DUT (
    .clk (clk),
    .rst (rst),
    .din (din_bus),
    .dout(dout_bus)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Idle lengths for both sides: mostly none or a few cycles, now and then
  // a long pause that lets the other side run dry or back up.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Values are mostly fully random, so that every bit takes both levels.
  // A share come from a narrow band to give equal neighbors, and a share
  // are the extremes of the signed range, zero or minus one.
  function automatic logic signed [DIS_VALUE_W-1:0] pick_value();
    logic signed [DIS_VALUE_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: v = $urandom;
      6, 7: v = $signed($urandom_range(0, 15)) - 32'sd8;
      default: begin
        case ($urandom_range(0, 3))
          0: v = VALUE_MAX;
          1: v = VALUE_MIN;
          2: v = '0;
          default: v = -32'sd1;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic push_word(input logic signed [DIS_VALUE_W-1:0] value, input logic last,
                           input int gap);
    input_word_t w;
    w.value = value;
    w.last  = last;
    w.gap   = gap;
    pending_words.push_back(w);
  endtask

  // Queues one random list of the given length. A burst list goes in back
  // to back, which gives stretches with no idling on the input side.
  task automatic push_list(input int len, input bit burst);
    int k;
    for (k = 0; k < len; k++) begin
      push_word(pick_value(), k == len - 1, burst ? 0 : pick_gap());
    end
  endtask

  // Predictor. Each accepted word goes into the held list, or is dropped
  // and noted when the list already fills the store. The word that closes
  // the list, stored or not, releases the held words sorted from the
  // largest to the smallest, each flagged with the list's overflow state.
  task automatic collect_word(input logic signed [DIS_VALUE_W-1:0] value,
                              input logic last);
    sorted_word_t                  res;
    logic signed [DIS_VALUE_W-1:0] key;
    int                            i;
    int                            j;
    if (held_values.size() < DIS_MAX_ITEMS) begin
      held_values.push_back(value);
    end else begin
      held_overflow = 1'b1;
    end
    if (last) begin
      // Insertion sort, larger values moving to the front. Both operands
      // are signed, so the comparison follows two's complement order.
      for (i = 1; i < held_values.size(); i++) begin
        key = held_values[i];
        j = i;
        while (j > 0 && key > held_values[j-1]) begin
          held_values[j] = held_values[j-1];
          j--;
        end
        held_values[j] = key;
      end
      for (i = 0; i < held_values.size(); i++) begin
        res.sorted_value = held_values[i];
        res.last_out     = (i == held_values.size() - 1);
        res.overflow     = held_overflow;
        sorted_expect.push_back(res);
      end
      held_values.delete();
      held_overflow = 1'b0;
    end
  endtask

  // Input driver. A new word is put up only when the channel is free, that
  // is when nothing is offered or the offered word is being taken at this
  // edge, and after the idle cycles that the previous word asked for. Each
  // signal gets at most one nonblocking assignment per edge, so a valid
  // that stays high across words never drops for a moment.
  always @(posedge clk) begin : input_driver
    input_word_t w;
    if (rst) begin
      in_valid  <= 1'b0;
      idle_left <= 0;
    end else if (!in_valid || din_bus.ready) begin
      if (idle_left != 0) begin
        in_valid  <= 1'b0;
        idle_left <= idle_left - 1;
      end else if (pending_words.size() != 0) begin
        w = pending_words.pop_front();
        in_valid  <= 1'b1;
        in_value  <= w.value;
        in_last   <= w.last;
        idle_left <= w.gap;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver. Ready drops for random stretches, but no new stretch starts
  // while bits 8:7 of the cycle counter are zero, one window in every four.
  always @(posedge clk) begin : output_sink
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (cycle_count[8:7] == 2'b00 || $urandom_range(0, 3) != 0) begin
      out_ready <= 1'b1;
    end else begin
      out_ready  <= 1'b0;
      stall_left <= pick_gap();
    end
  end

  // Monitor. Both channels are sampled at the rising edge, which sees the
  // values from before the edge. Input words feed the predictor first, so
  // an expectation is always in place before its result can show up.
  always @(posedge clk) begin : monitor
    sorted_word_t exp_word;
    if (!rst) begin
      if (din_bus.valid && din_bus.ready) begin
        collect_word(din_bus.value, din_bus.last);
      end
      if (dout_bus.valid && dout_bus.ready) begin
        if (sorted_expect.size() == 0) begin
          $error("unexpected output word: sorted_value %0d last_out %0b overflow %0b",
                 dout_bus.sorted_value, dout_bus.last_out, dout_bus.overflow);
          error_count++;
        end else begin
          exp_word = sorted_expect.pop_front();
          if (dout_bus.sorted_value !== exp_word.sorted_value) begin
            $error("sorted_value: expected %0d, actual %0d",
                   exp_word.sorted_value, dout_bus.sorted_value);
            error_count++;
          end
          if (dout_bus.last_out !== exp_word.last_out) begin
            $error("last_out: expected %0b, actual %0b",
                   exp_word.last_out, dout_bus.last_out);
            error_count++;
          end
          if (dout_bus.overflow !== exp_word.overflow) begin
            $error("overflow: expected %0b, actual %0b",
                   exp_word.overflow, dout_bus.overflow);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog on the cycle counter.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("tb_descending_integer_sorter_core: FAIL");
    $finish;
  end

  initial begin : stimulus
    int random_words;
    int len;

    // Directed lists. Single-word lists at the extremes of the signed
    // range and at zero, a mixed list that crosses the sign boundary, a
    // list with repeated values, and lists given in descending and in
    // ascending order.
    push_word(VALUE_MAX, 1'b1, 0);
    push_word(VALUE_MIN, 1'b1, 2);
    push_word('0, 1'b1, 0);
    push_word(-32'sd1, 1'b0, 0);
    push_word(32'sd1, 1'b0, 1);
    push_word('0, 1'b0, 0);
    push_word(VALUE_MIN, 1'b0, 0);
    push_word(VALUE_MAX, 1'b1, 0);
    push_word(32'sd7, 1'b0, 0);
    push_word(32'sd7, 1'b0, 0);
    push_word(-32'sd3, 1'b0, 0);
    push_word(32'sd7, 1'b0, 0);
    push_word(-32'sd3, 1'b1, 3);
    for (int k = 5; k >= 1; k--) push_word(k, k == 1, 0);
    for (int k = 1; k <= 5; k++) push_word(k, k == 5, 1);

    // Capacity cases: a list that exactly fills the store, one whose
    // closing word finds the store full and is dropped, and one that
    // overruns the store by several words. After these, random lists,
    // mostly short, now and then near the store's size, at times filling or overrunning it.
    push_list(DIS_MAX_ITEMS, 1'b0);
    push_list(DIS_MAX_ITEMS + 1, 1'b1);
    push_list(DIS_MAX_ITEMS + 6, 1'b0);
    random_words = pending_words.size();
    while (random_words < RANDOM_WORDS) begin
      if ($urandom_range(0, 11) == 0) begin
        len = $urandom_range(DIS_MAX_ITEMS - 4, DIS_MAX_ITEMS + 4);
      end else begin
        len = $urandom_range(1, 8);
      end
      push_list(len, $urandom_range(0, 3) == 0);
      random_words += len;
    end

    // Reset is held once, at the start of the run.
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Wait for the driver to run dry, then for every predicted word, then
    // keep watching for a while for words that should not come.
    while (pending_words.size() != 0 || in_valid) @(posedge clk);
    while (sorted_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && sorted_expect.size() == 0) begin
      $display("tb_descending_integer_sorter_core: PASS");
    end else begin
      $display("tb_descending_integer_sorter_core: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
